[sv/tbkv_pkg.sv]
// Shared constants and types of the tagged bucket key-value store.
package tbkv_pkg;

  localparam int BUCKETS   = 1024;
  localparam int WAYS      = 8;
  localparam int ITEMS     = 8192;
  localparam int BUCKET_AW = $clog2(BUCKETS);
  localparam int ITEM_AW   = $clog2(ITEMS);
  localparam int WAY_W     = $clog2(WAYS);
  localparam int TAG_W     = 16;
  localparam int SLOT_W    = TAG_W + ITEM_AW;
  localparam int ROW_W     = SLOT_W * WAYS;
  localparam int CNT_W     = 14;
  localparam int KEY_W     = 64;
  localparam int ITEM_W    = 3 * KEY_W;

  localparam logic [31:0] C1  = 32'h239b961b;
  localparam logic [31:0] C2  = 32'hab0e9789;
  localparam logic [31:0] C3  = 32'h38b34ae5;
  localparam logic [31:0] FM1 = 32'h85ebca6b;
  localparam logic [31:0] FM2 = 32'hc2b2ae35;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_DUP      = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_SEED  = 2'd0,
    REG_BBITS = 2'd1,
    REG_LIMIT = 2'd2
  } cfg_reg_e;

endpackage

[sv/tagged_bucket_kv_store.sv]
// Tagged bucket key-value store: hash, bucket scan and item update engine.
//
// Each word carries a get or set on a 64-bit key. The key is hashed (low word of a
// 128-bit x86 MurmurHash3 with a programmable seed); digest bits 15..0 are a tag and
// bits 16 and up pick one of 1024 buckets of 8 slots. One item is handled at a time:
// it is accepted, hashed through states S_HA to S_HG and its bucket row read; then
// the ways are scanned one by one, each tag match adding an item memory read and key
// compare in the single-port item memory, and a last step updates and posts the
// result once the output register is free. The result sits in an output register,
// so a new word is taken while the last result waits. After reset the block sweeps
// all 1024 bucket rows to empty, one row a cycle, and accepts no word until then;
// configuration writes are taken at any time.
module tagged_bucket_kv_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [63:0] key_i,
  input  logic [63:0] value_i,
  input  logic [63:0] seq_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] value_out_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HA, S_HB, S_HC, S_HD, S_HE, S_HF, S_HG,
    S_BRD, S_SCAN, S_ICMP, S_ACT
  } state_e;

  state_e state_q;

  // configuration
  logic [31:0]                 seed_q;
  logic [3:0]                  bbits_q;
  logic [tbkv_pkg::CNT_W-1:0]  limit_q;

  // request
  logic        kind_q;
  logic [63:0] key_q, value_q, seq_q;

  // hash lanes
  logic [31:0] k1_q, k2_q;
  logic [31:0] hv_q [4];
  logic [31:0] x16 [4];
  logic [31:0] x13 [4];

  // scan state
  logic [tbkv_pkg::TAG_W-1:0]     tag_q;
  logic [tbkv_pkg::BUCKET_AW-1:0] bidx_q, clr_q, bidx;
  logic [tbkv_pkg::WAY_W-1:0]     way_q;
  logic [tbkv_pkg::ITEM_AW-1:0]   hit_ix_q;
  logic                           hit_q, free_q;
  logic [tbkv_pkg::CNT_W-1:0]     cnt_q;

  // result register
  logic                  out_valid_q;
  tbkv_pkg::status_e     status_q;
  logic [63:0]           vout_q;

  // memories
  logic                           bkt_we, bkt_re;
  logic [tbkv_pkg::BUCKET_AW-1:0] bkt_addr;
  logic [tbkv_pkg::ROW_W-1:0]     bkt_wdata, bkt_rdata;
  logic                           itm_we, itm_re;
  logic [tbkv_pkg::ITEM_AW-1:0]   itm_addr;
  logic [tbkv_pkg::ITEM_W-1:0]    itm_wdata, itm_rdata;

  logic [tbkv_pkg::SLOT_W-1:0]    slot;
  logic                           last_way;
  logic [63:0]                    itm_key, itm_val, itm_seq;
  logic [tbkv_pkg::BUCKET_AW:0]   bmask;
  logic                           act_go, do_new, new_ok;
  tbkv_pkg::status_e              act_status;
  logic [63:0]                    act_vout;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_out_o = vout_q;

  // fmix helpers, one per lane
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      x16[i] = hv_q[i] ^ (hv_q[i] >> 16);
      x13[i] = hv_q[i] ^ (hv_q[i] >> 13);
    end
  end

  // bucket index: digest bits above the tag, masked to bucket_bits, wrapped to the table
  always_comb begin
    if (bbits_q >= 4'(tbkv_pkg::BUCKET_AW)) begin
      bmask = '1;
    end else begin
      bmask = ((tbkv_pkg::BUCKET_AW+1)'(1) << bbits_q) - (tbkv_pkg::BUCKET_AW+1)'(1);
    end
    bidx = hv_q[0][tbkv_pkg::TAG_W +: tbkv_pkg::BUCKET_AW]
           & bmask[tbkv_pkg::BUCKET_AW-1:0];
  end

  assign slot     = bkt_rdata[way_q*tbkv_pkg::SLOT_W +: tbkv_pkg::SLOT_W];
  assign last_way = (way_q == tbkv_pkg::WAY_W'(tbkv_pkg::WAYS - 1));
  assign itm_key  = itm_rdata[2*64 +: 64];
  assign itm_val  = itm_rdata[64 +: 64];
  assign itm_seq  = itm_rdata[63:0];
  assign act_go   = (state_q == S_ACT) && (!out_valid_q || out_ready_i);

  // decide the outcome of the scanned request
  always_comb begin
    act_vout   = value_q;
    act_status = tbkv_pkg::ST_OK;
    do_new     = 1'b0;
    new_ok     = (cnt_q < limit_q) && (cnt_q < tbkv_pkg::CNT_W'(tbkv_pkg::ITEMS))
                 && (cnt_q != '0);
    if (!kind_q) begin
      if (hit_q) begin
        act_vout = itm_val;
      end else begin
        act_status = tbkv_pkg::ST_NOTFOUND;
      end
    end else if (hit_q) begin
      if (seq_q != '0 && itm_seq >= seq_q) begin
        act_status = tbkv_pkg::ST_DUP;
      end
    end else if (!free_q) begin
      act_status = tbkv_pkg::ST_FULL;
    end else begin
      do_new = 1'b1;
      if (!new_ok) begin
        act_status = tbkv_pkg::ST_FULL;
      end
    end
  end

  // memory ports
  always_comb begin
    bkt_we    = 1'b0;
    bkt_re    = 1'b0;
    bkt_addr  = bidx_q;
    bkt_wdata = bkt_rdata;
    bkt_wdata[way_q*tbkv_pkg::SLOT_W +: tbkv_pkg::SLOT_W] =
      {tag_q, cnt_q[tbkv_pkg::ITEM_AW-1:0]};
    itm_we    = 1'b0;
    itm_re    = 1'b0;
    itm_addr  = slot[tbkv_pkg::ITEM_AW-1:0];
    itm_wdata = {key_q, value_q, seq_q};
    case (state_q)
      S_CLR: begin
        bkt_we    = 1'b1;
        bkt_addr  = clr_q;
        bkt_wdata = '0;
      end
      S_BRD: begin
        bkt_re   = 1'b1;
        bkt_addr = bidx;
      end
      S_SCAN: begin
        itm_re = (slot != '0) && (slot[tbkv_pkg::ITEM_AW +: tbkv_pkg::TAG_W] == tag_q);
      end
      S_ACT: begin
        if (hit_q) begin
          itm_addr = hit_ix_q;
          itm_we   = act_go && kind_q && (act_status == tbkv_pkg::ST_OK);
        end else begin
          itm_addr = cnt_q[tbkv_pkg::ITEM_AW-1:0];
          itm_we   = act_go && do_new && new_ok;
          bkt_we   = act_go && do_new && new_ok;
        end
      end
      default: begin
      end
    endcase
  end

  tbkv_ram #(.W(tbkv_pkg::ROW_W), .D(tbkv_pkg::BUCKETS)) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .re_i    (bkt_re),
    .addr_i  (bkt_addr),
    .wdata_i (bkt_wdata),
    .rdata_o (bkt_rdata)
  );

  tbkv_ram #(.W(tbkv_pkg::ITEM_W), .D(tbkv_pkg::ITEMS)) u_itm_ram (
    .clk_i   (clk_i),
    .we_i    (itm_we),
    .re_i    (itm_re),
    .addr_i  (itm_addr),
    .wdata_i (itm_wdata),
    .rdata_o (itm_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      seed_q      <= '0;
      bbits_q     <= 4'(tbkv_pkg::BUCKET_AW);
      limit_q     <= tbkv_pkg::CNT_W'(tbkv_pkg::ITEMS);
      cnt_q       <= tbkv_pkg::CNT_W'(1);
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      way_q       <= '0;
    end else begin
      // configuration words land at once
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tbkv_pkg::REG_SEED:  seed_q  <= cfg_data_i;
          tbkv_pkg::REG_BBITS: bbits_q <= cfg_data_i[3:0];
          tbkv_pkg::REG_LIMIT: limit_q <= cfg_data_i[tbkv_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
      // drop the taken result unless a new one replaces it this cycle
      if (out_valid_q && out_ready_i && !act_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= kind_i;
            key_q   <= key_i;
            value_q <= value_i;
            seq_q   <= seq_i;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            way_q   <= '0;
            state_q <= S_HA;
          end
        end
        S_HA: begin
          k1_q    <= key_q[31:0] * tbkv_pkg::C1;
          k2_q    <= key_q[63:32] * tbkv_pkg::C2;
          state_q <= S_HB;
        end
        S_HB: begin
          k1_q    <= {k1_q[16:0], k1_q[31:17]} * tbkv_pkg::C2;
          k2_q    <= {k2_q[15:0], k2_q[31:16]} * tbkv_pkg::C3;
          state_q <= S_HC;
        end
        S_HC: begin
          hv_q[0] <= (seed_q ^ k1_q ^ 32'd8) + (seed_q ^ k2_q ^ 32'd8)
                     + (seed_q ^ 32'd8) + (seed_q ^ 32'd8);
          hv_q[1] <= seed_q ^ k2_q ^ 32'd8;
          hv_q[2] <= seed_q ^ 32'd8;
          hv_q[3] <= seed_q ^ 32'd8;
          state_q <= S_HD;
        end
        S_HD: begin
          hv_q[1] <= hv_q[1] + hv_q[0];
          hv_q[2] <= hv_q[2] + hv_q[0];
          hv_q[3] <= hv_q[3] + hv_q[0];
          state_q <= S_HE;
        end
        S_HE: begin
          for (int i = 0; i < 4; i++) begin
            hv_q[i] <= x16[i] * tbkv_pkg::FM1;
          end
          state_q <= S_HF;
        end
        S_HF: begin
          for (int i = 0; i < 4; i++) begin
            hv_q[i] <= x13[i] * tbkv_pkg::FM2;
          end
          state_q <= S_HG;
        end
        S_HG: begin
          // final mix; only the low lane of the digest matters downstream
          hv_q[0] <= x16[0] + x16[1] + x16[2] + x16[3];
          state_q <= S_BRD;
        end
        S_BRD: begin
          bidx_q  <= bidx;
          tag_q   <= hv_q[0][tbkv_pkg::TAG_W-1:0];
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (slot == '0) begin
            free_q  <= 1'b1;
            state_q <= S_ACT;
          end else if (slot[tbkv_pkg::ITEM_AW +: tbkv_pkg::TAG_W] == tag_q) begin
            hit_ix_q <= slot[tbkv_pkg::ITEM_AW-1:0];
            state_q  <= S_ICMP;
          end else if (last_way) begin
            state_q <= S_ACT;
          end else begin
            way_q <= way_q + 1'b1;
          end
        end
        S_ICMP: begin
          if (itm_key == key_q) begin
            hit_q   <= 1'b1;
            state_q <= S_ACT;
          end else if (last_way) begin
            state_q <= S_ACT;
          end else begin
            way_q   <= way_q + 1'b1;
            state_q <= S_SCAN;
          end
        end
        S_ACT: begin
          // hold until the output register is free
          if (act_go) begin
            status_q    <= act_status;
            vout_q      <= act_vout;
            out_valid_q <= 1'b1;
            if (do_new && cnt_q != '1) begin
              cnt_q <= cnt_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/tbkv_ram.sv]
// Generic single-port synchronous RAM with registered read.
module tbkv_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] addr_i,
  input  logic [W-1:0]         wdata_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

[sv/tbkv_chk.sv]
// Port-level checker for the tagged bucket key-value store, with its bind.
module tbkv_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_ready_o,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [63:0] value_out_o
);

  // a taken word keeps the block busy through hash states S_HA and S_HB
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken again during hash");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port stalled");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(value_out_o))
    else $error("result word changed while stalled");

endmodule

bind tagged_bucket_kv_store tbkv_chk u_tbkv_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready_o (cfg_ready_o),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .value_out_o (value_out_o)
);
